// File: src/chs_pkg.sv
// ----------------------------------------------------------------------------
// Cholesky 3x3 solver package
// Shared types, the working-register slot map and the operation schedule
// of the solver pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

    localparam int IW = 64;

    typedef logic signed [IW-1:0] val_t;

    localparam val_t IMAX = {1'b0, {(IW-1){1'b1}}};

    typedef enum logic [4:0] {
        S_A00, S_A10, S_A11, S_A20, S_A21, S_A22,
        S_NB0, S_NB1, S_NB2,
        S_L00, S_L10, S_L11, S_L20, S_L21, S_L22,
        S_Y0, S_Y1, S_Y2,
        S_X0, S_X1, S_X2,
        S_T
    } slot_t;

    localparam int NSLOT = 22;

    typedef struct packed {
        logic                      npd;
        logic                      sat;
        logic [NSLOT-1:0][IW-1:0]  r;
    } item_t;

    typedef enum logic [1:0] {
        OP_MULSUB = 2'd0,
        OP_DIV    = 2'd1,
        OP_SQRT   = 2'd2
    } op_t;

    typedef struct packed {
        op_t   kind;
        slot_t a;
        slot_t b;
        slot_t c;
        slot_t d;
    } op_desc_t;

    localparam int NOPS = 22;

    // A multiply-subtract computes d = c - a * b; a divide d = a / b; a root d = sqrt(a).
    localparam op_desc_t OPS [NOPS] = '{
        '{OP_SQRT,   S_A00, S_T,   S_T,   S_L00},
        '{OP_DIV,    S_A10, S_L00, S_T,   S_L10},
        '{OP_MULSUB, S_L10, S_L10, S_A11, S_T},
        '{OP_SQRT,   S_T,   S_T,   S_T,   S_L11},
        '{OP_DIV,    S_A20, S_L00, S_T,   S_L20},
        '{OP_MULSUB, S_L20, S_L10, S_A21, S_T},
        '{OP_DIV,    S_T,   S_L11, S_T,   S_L21},
        '{OP_MULSUB, S_L20, S_L20, S_A22, S_T},
        '{OP_MULSUB, S_L21, S_L21, S_T,   S_T},
        '{OP_SQRT,   S_T,   S_T,   S_T,   S_L22},
        '{OP_DIV,    S_NB0, S_L00, S_T,   S_Y0},
        '{OP_MULSUB, S_L10, S_Y0,  S_NB1, S_T},
        '{OP_DIV,    S_T,   S_L11, S_T,   S_Y1},
        '{OP_MULSUB, S_L20, S_Y0,  S_NB2, S_T},
        '{OP_MULSUB, S_L21, S_Y1,  S_T,   S_T},
        '{OP_DIV,    S_T,   S_L22, S_T,   S_Y2},
        '{OP_DIV,    S_Y2,  S_L22, S_T,   S_X2},
        '{OP_MULSUB, S_L21, S_X2,  S_Y1,  S_T},
        '{OP_DIV,    S_T,   S_L11, S_T,   S_X1},
        '{OP_MULSUB, S_L10, S_X1,  S_Y0,  S_T},
        '{OP_MULSUB, S_L20, S_X2,  S_T,   S_T},
        '{OP_DIV,    S_T,   S_L00, S_T,   S_X0}
    };

    function automatic logic [IW-2:0] mag(input val_t v);
        logic [IW-1:0] n;
        n = -v;
        return v[IW-1] ? n[IW-2:0] : v[IW-2:0];
    endfunction

endpackage

`default_nettype wire

// File: src/cholesky_solve_3x3_unit.sv
// ----------------------------------------------------------------------------
// Cholesky 3x3 solver
// The nine divides (65 stages each, one quotient bit per stage) and the three
// square roots sit in one long chain. Throughput: one item per cycle while the
// skid register is empty; the skid register lets the pipe take a new item while
// a finished result waits. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cholesky_solve_3x3_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [WORD_BITS-1:0] a_00,
    input  logic signed [WORD_BITS-1:0] a_10,
    input  logic signed [WORD_BITS-1:0] a_11,
    input  logic signed [WORD_BITS-1:0] a_20,
    input  logic signed [WORD_BITS-1:0] a_21,
    input  logic signed [WORD_BITS-1:0] a_22,
    input  logic signed [WORD_BITS-1:0] b_0,
    input  logic signed [WORD_BITS-1:0] b_1,
    input  logic signed [WORD_BITS-1:0] b_2,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [WORD_BITS-1:0] x_0,
    output logic signed [WORD_BITS-1:0] x_1,
    output logic signed [WORD_BITS-1:0] x_2,
    output logic                        not_pos_definite,
    output logic                        overflowed
);
    import chs_pkg::*;

    localparam val_t WMAX = IMAX >>> (IW - WORD_BITS);
    localparam val_t WMIN = -WMAX - val_t'(1);

    typedef struct packed {
        logic [WORD_BITS-1:0] x0;
        logic [WORD_BITS-1:0] x1;
        logic [WORD_BITS-1:0] x2;
        logic                 npd;
        logic                 ovf;
    } res_t;

    function automatic val_t widen(input logic signed [WORD_BITS-1:0] w);
        val_t v;
        v = val_t'(w);
        if (v == {1'b1, {(IW-1){1'b0}}})
        begin
            v = -IMAX;
        end
        return v;
    endfunction

    function automatic logic [WORD_BITS:0] fit(input val_t v);
        logic [WORD_BITS:0] r;
        if (v > WMAX)
        begin
            r = {1'b1, WMAX[WORD_BITS-1:0]};
        end
        else if (v < WMIN)
        begin
            r = {1'b1, WMIN[WORD_BITS-1:0]};
        end
        else
        begin
            r = {1'b0, v[WORD_BITS-1:0]};
        end
        return r;
    endfunction

    item_t chain  [NOPS+1];
    logic  vchain [NOPS+1];
    logic  adv;
    res_t  fin;
    res_t  out_reg;
    res_t  skid_reg;
    logic  out_vld_reg;
    logic  skid_vld_reg;
    logic [WORD_BITS:0] f0, f1, f2;

    assign adv       = !skid_vld_reg;
    assign in_stall  = skid_vld_reg;
    assign vchain[0] = in_valid;

    always_comb
    begin
        chain[0]          = '0;
        chain[0].r[S_A00] = widen(a_00);
        chain[0].r[S_A10] = widen(a_10);
        chain[0].r[S_A11] = widen(a_11);
        chain[0].r[S_A20] = widen(a_20);
        chain[0].r[S_A21] = widen(a_21);
        chain[0].r[S_A22] = widen(a_22);
        chain[0].r[S_NB0] = -widen(b_0);
        chain[0].r[S_NB1] = -widen(b_1);
        chain[0].r[S_NB2] = -widen(b_2);
    end

    for (genvar i = 0; i < NOPS; i++) begin : g_op
        chs_op #(
            .KIND      (OPS[i].kind),
            .SA        (OPS[i].a),
            .SB        (OPS[i].b),
            .SC        (OPS[i].c),
            .DST       (OPS[i].d),
            .FRAC_BITS (FRAC_BITS)
        ) u_op (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .vld_in   (vchain[i]),
            .item_in  (chain[i]),
            .vld_out  (vchain[i+1]),
            .item_out (chain[i+1])
        );
    end

    always_comb
    begin
        f0      = fit(val_t'(chain[NOPS].r[S_X0]));
        f1      = fit(val_t'(chain[NOPS].r[S_X1]));
        f2      = fit(val_t'(chain[NOPS].r[S_X2]));
        fin.npd = chain[NOPS].npd;
        fin.x0  = fin.npd ? '0 : f0[WORD_BITS-1:0];
        fin.x1  = fin.npd ? '0 : f1[WORD_BITS-1:0];
        fin.x2  = fin.npd ? '0 : f2[WORD_BITS-1:0];
        fin.ovf = !fin.npd && (chain[NOPS].sat || f0[WORD_BITS] || f1[WORD_BITS]
                               || f2[WORD_BITS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_vld_reg)
            begin
                if (!out_stall)
                begin
                    skid_vld_reg <= 1'b0;
                end
            end
            else if (out_vld_reg && out_stall)
            begin
                skid_vld_reg <= vchain[NOPS];
            end
            else
            begin
                out_vld_reg <= vchain[NOPS];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_vld_reg)
        begin
            if (!out_stall)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (out_vld_reg && out_stall)
        begin
            skid_reg <= fin;
        end
        else
        begin
            out_reg <= fin;
        end
    end

    assign out_valid        = out_vld_reg;
    assign x_0              = out_reg.x0;
    assign x_1              = out_reg.x1;
    assign x_2              = out_reg.x2;
    assign not_pos_definite = out_reg.npd;
    assign overflowed       = out_reg.ovf;

endmodule

`default_nettype wire

// File: src/chs_op.sv
// ----------------------------------------------------------------------------
// Cholesky solver operation stage
// One pipelined arithmetic operation on the carried working registers:
// multiply-subtract, restoring divide (one quotient bit per stage) or
// digit-by-digit square root (one root bit per stage).
// ----------------------------------------------------------------------------
`default_nettype none

module chs_op #(
    parameter chs_pkg::op_t   KIND      = chs_pkg::OP_MULSUB,
    parameter chs_pkg::slot_t SA        = chs_pkg::S_T,
    parameter chs_pkg::slot_t SB        = chs_pkg::S_T,
    parameter chs_pkg::slot_t SC        = chs_pkg::S_T,
    parameter chs_pkg::slot_t DST       = chs_pkg::S_T,
    parameter int             FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vld_in,
    input  chs_pkg::item_t item_in,
    output logic           vld_out,
    output chs_pkg::item_t item_out
);
    import chs_pkg::*;

    localparam int QB  = IW - 1;
    localparam int RB  = (IW + FRAC_BITS) / 2;
    localparam int LAT = (KIND == OP_MULSUB) ? 3 : ((KIND == OP_DIV) ? QB + 2 : RB + 2);

    item_t pay_reg  [LAT];
    item_t pay_next [LAT];
    logic  vld_reg  [LAT];
    val_t  res_val;
    logic  res_sat;
    logic  npd_set;

    always_comb
    begin
        pay_next[0]     = item_in;
        pay_next[0].npd = item_in.npd | npd_set;
        for (int k = 1; k < LAT; k++)
        begin
            pay_next[k] = pay_reg[k-1];
        end
        pay_next[LAT-1].r[DST] = res_val;
        pay_next[LAT-1].sat    = pay_reg[LAT-2].sat | res_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= vld_in;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                pay_reg[k] <= pay_next[k];
            end
        end
    end

    assign vld_out  = vld_reg[LAT-1];
    assign item_out = pay_reg[LAT-1];

    if (KIND == OP_MULSUB) begin : g_mul
        localparam int H = IW / 2;
        localparam logic [2*IW-1:0] RND = (2*IW)'(1) << (FRAC_BITS - 1);

        logic [IW-2:0]   am;
        logic [IW-2:0]   bm;
        logic [IW-1:0]   p00_reg, p01_reg, p10_reg, p11_reg;
        logic            neg_reg;
        val_t            prod_reg;
        logic            psat_reg;
        logic [2*IW-1:0] sum;
        logic [2*IW-1:0] mq;
        logic            big;
        logic [IW-2:0]   mv;
        val_t            prod_next;
        val_t            cv;
        logic [IW:0]     diff;
        logic            posov;
        logic            negov;

        assign am = mag(val_t'(item_in.r[SA]));
        assign bm = mag(val_t'(item_in.r[SB]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p00_reg  <= am[H-1:0] * bm[H-1:0];
                p01_reg  <= am[H-1:0] * bm[IW-2:H];
                p10_reg  <= am[IW-2:H] * bm[H-1:0];
                p11_reg  <= am[IW-2:H] * bm[IW-2:H];
                neg_reg  <= item_in.r[SA][IW-1] ^ item_in.r[SB][IW-1];
                prod_reg <= prod_next;
                psat_reg <= big;
            end
        end

        always_comb
        begin
            sum = ((2*IW)'(p11_reg) << IW) + ((2*IW)'(p01_reg) << H)
                + ((2*IW)'(p10_reg) << H) + (2*IW)'(p00_reg) + RND;
            mq  = sum >> FRAC_BITS;
            big = |mq[2*IW-1:IW-1];
            mv  = big ? IMAX[IW-2:0] : mq[IW-2:0];
            prod_next = neg_reg ? -val_t'({1'b0, mv}) : val_t'({1'b0, mv});
        end

        always_comb
        begin
            cv    = val_t'(pay_reg[1].r[SC]);
            diff  = {cv[IW-1], cv} - {prod_reg[IW-1], prod_reg};
            posov = !diff[IW] && diff[IW-1];
            negov = diff[IW] && (!diff[IW-1] || (diff[IW-2:0] == '0));
            if (posov)
            begin
                res_val = IMAX;
            end
            else if (negov)
            begin
                res_val = -IMAX;
            end
            else
            begin
                res_val = val_t'(diff[IW-1:0]);
            end
            res_sat = psat_reg | posov | negov;
        end

        assign npd_set = 1'b0;
    end
    else if (KIND == OP_DIV) begin : g_div
        localparam int SH = IW - 1 - FRAC_BITS;

        logic [IW-2:0] rem_reg [QB+1];
        logic [IW-2:0] q_reg   [QB+1];
        logic [IW-2:0] low_reg [QB+1];
        logic [IW-2:0] dm_reg  [QB+1];
        logic          neg_reg [QB+1];
        logic          big_reg [QB+1];
        logic [IW-2:0] rem_next [QB+1];
        logic [IW-2:0] q_next   [QB+1];
        logic [IW-2:0] low_next [QB+1];
        logic [IW-2:0] nm;
        logic [IW-2:0] dm;
        logic [IW-2:0] hi0;
        logic [IW-2:0] rr;
        logic [IW-2:0] dd;
        logic          up;
        logic [IW-1:0] qq;
        logic          qsat;
        logic [IW-2:0] mv;

        always_comb
        begin
            logic [IW-1:0] t;
            logic [IW-1:0] dif;
            nm          = mag(val_t'(item_in.r[SA]));
            dm          = mag(val_t'(item_in.r[SB]));
            hi0         = nm >> SH;
            rem_next[0] = hi0;
            q_next[0]   = '0;
            low_next[0] = nm << FRAC_BITS;
            for (int s = 1; s <= QB; s++)
            begin
                t   = {rem_reg[s-1], low_reg[s-1][IW-2]};
                dif = t - {1'b0, dm_reg[s-1]};
                if (t >= {1'b0, dm_reg[s-1]})
                begin
                    rem_next[s] = dif[IW-2:0];
                    q_next[s]   = {q_reg[s-1][IW-3:0], 1'b1};
                end
                else
                begin
                    rem_next[s] = t[IW-2:0];
                    q_next[s]   = {q_reg[s-1][IW-3:0], 1'b0};
                end
                low_next[s] = low_reg[s-1] << 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[0] <= rem_next[0];
                q_reg[0]   <= q_next[0];
                low_reg[0] <= low_next[0];
                dm_reg[0]  <= dm;
                neg_reg[0] <= item_in.r[SA][IW-1] ^ item_in.r[SB][IW-1];
                big_reg[0] <= hi0 >= dm;
                for (int s = 1; s <= QB; s++)
                begin
                    rem_reg[s] <= rem_next[s];
                    q_reg[s]   <= q_next[s];
                    low_reg[s] <= low_next[s];
                    dm_reg[s]  <= dm_reg[s-1];
                    neg_reg[s] <= neg_reg[s-1];
                    big_reg[s] <= big_reg[s-1];
                end
            end
        end

        always_comb
        begin
            rr      = rem_reg[QB];
            dd      = dm_reg[QB];
            up      = rr >= (dd - rr);
            qq      = {1'b0, q_reg[QB]} + IW'(up);
            qsat    = big_reg[QB] | qq[IW-1];
            mv      = qsat ? IMAX[IW-2:0] : qq[IW-2:0];
            res_val = neg_reg[QB] ? -val_t'({1'b0, mv}) : val_t'({1'b0, mv});
            res_sat = qsat;
        end

        assign npd_set = 1'b0;
    end
    else begin : g_sqrt
        logic [2*RB-1:0] rad_reg  [RB+1];
        logic [RB:0]     rem_reg  [RB+1];
        logic [RB-1:0]   root_reg [RB+1];
        logic [2*RB-1:0] rad_next [RB+1];
        logic [RB:0]     rem_next [RB+1];
        logic [RB-1:0]   root_next[RB+1];
        val_t            v;

        assign v       = val_t'(item_in.r[SA]);
        assign npd_set = v[IW-1] || (v == '0);

        always_comb
        begin
            logic [RB+2:0] t;
            logic [RB+2:0] trial;
            logic [RB+2:0] dif;
            rad_next[0]  = (2*RB)'(mag(v)) << FRAC_BITS;
            rem_next[0]  = '0;
            root_next[0] = '0;
            for (int s = 1; s <= RB; s++)
            begin
                t     = {rem_reg[s-1], rad_reg[s-1][2*RB-1:2*RB-2]};
                trial = {1'b0, root_reg[s-1], 2'b01};
                dif   = t - trial;
                if (t >= trial)
                begin
                    rem_next[s]  = dif[RB:0];
                    root_next[s] = {root_reg[s-1][RB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s]  = t[RB:0];
                    root_next[s] = {root_reg[s-1][RB-2:0], 1'b0};
                end
                rad_next[s] = rad_reg[s-1] << 2;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int s = 0; s <= RB; s++)
                begin
                    rad_reg[s]  <= rad_next[s];
                    rem_reg[s]  <= rem_next[s];
                    root_reg[s] <= root_next[s];
                end
            end
        end

        assign res_val = val_t'(IW'(root_reg[RB]));
        assign res_sat = 1'b0;
    end

endmodule

`default_nettype wire

// File: src/chs_checker.sv
// ----------------------------------------------------------------------------
// Cholesky 3x3 solver port checker
// Watches the solver ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_checker #(
    parameter int WORD_BITS = 32
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic signed [WORD_BITS-1:0] x_0,
    input wire logic signed [WORD_BITS-1:0] x_1,
    input wire logic signed [WORD_BITS-1:0] x_2,
    input wire logic                        not_pos_definite,
    input wire logic                        overflowed
);

    a_npd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && not_pos_definite) |->
        (x_0 == '0 && x_1 == '0 && x_2 == '0 && !overflowed))
        else $error("Item flagged not positive definite carries a nonzero solution.");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(not_pos_definite && overflowed))
        else $error("Item carries both the definiteness and the overflow flag.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("Input stalled without a blocked result on the output.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(x_0) && $stable(x_1)
                                      && $stable(x_2)))
        else $error("Stalled output item changed.");

endmodule

bind cholesky_solve_3x3_unit chs_checker #(.WORD_BITS(WORD_BITS)) u_chs_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .x_0              (x_0),
    .x_1              (x_1),
    .x_2              (x_2),
    .not_pos_definite (not_pos_definite),
    .overflowed       (overflowed)
);

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the Cholesky 3x3 solver
// Sends a short table of hand-picked systems, then about 1650 random ones,
// most of them positive definite with random scaling and the rest raw bit
// noise. The sender works in random bursts and the receiver stalls on its
// own pattern. Every solution is checked field by field against the expected
// value in the table or an in-bench fixed-point predictor of the factor-and-substitute solve.
// ----------------------------------------------------------------------------

module tb_top;

    import chs_pkg::*;

    localparam int       N_RANDOM   = 1650;
    localparam int       LATENCY    = 741;
    localparam int       CYCLE_CAP  = 400000;
    localparam longint   I64MAX     = 64'sh7fff_ffff_ffff_ffff;
    localparam logic [31:0] ONE_Q   = 32'h0001_0000;
    localparam logic [31:0] MAX32   = 32'h7fff_ffff;
    localparam logic [31:0] MIN32   = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] x2;
        logic        npd;
        logic        ovf;
    } solution_t;

    typedef struct packed {
        logic [8:0][31:0] v;
        logic             typed;
        solution_t        want;
    } system_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic out_valid;
    logic out_stall;
    logic [8:0][31:0] drv;
    logic signed [31:0] x_0, x_1, x_2;
    logic not_pos_definite, overflowed;

    solution_t   pending_solutions[$];
    system_row_t table_rows[$];
    bit          sat_hit;
    int          fail_count;
    int          cycle_count;

    cholesky_solve_3x3_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a_00(drv[0]), .a_10(drv[1]), .a_11(drv[2]),
        .a_20(drv[3]), .a_21(drv[4]), .a_22(drv[5]),
        .b_0(drv[6]), .b_1(drv[7]), .b_2(drv[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .x_0(x_0), .x_1(x_1), .x_2(x_2),
        .not_pos_definite(not_pos_definite), .overflowed(overflowed)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] mag64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint signed_of(input bit neg, input logic [127:0] m);
        logic [63:0] r;
        if (m > 128'(I64MAX))
        begin
            sat_hit = 1'b1;
            r = I64MAX;
        end
        else
            r = m[63:0];
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        logic [127:0] p;
        p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        p = (p + 128'd32768) >> 16;
        return signed_of((a < 0) != (b < 0), p);
    endfunction

    function automatic longint q_div(input longint n, input longint d);
        logic [127:0] num, dm, q, r;
        num = {64'd0, mag64(n)} << 16;
        dm = {64'd0, mag64(d)};
        if (dm == 0)
            return signed_of(n < 0, num == 0 ? 128'd0 : {128{1'b1}});
        q = num / dm;
        r = num % dm;
        if (r >= dm - r)
            q = q + 1;
        return signed_of((n < 0) != (d < 0), q);
    endfunction

    function automatic longint q_root(input longint v);
        logic [127:0] target, t;
        logic [63:0] r;
        target = {64'd0, mag64(v)} << 16;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = {64'd0, r | (64'd1 << i)};
            if (t * t <= target)
                r = t[63:0];
        end
        return longint'(r);
    endfunction

    function automatic longint q_sub(input longint a, input longint b);
        longint nb;
        nb = -b;
        if (nb > 0 && a > I64MAX - nb)
        begin
            sat_hit = 1'b1;
            return I64MAX;
        end
        if (nb < 0 && a < -I64MAX - nb)
        begin
            sat_hit = 1'b1;
            return -I64MAX;
        end
        return a + nb;
    endfunction

    function automatic logic [31:0] clamp_word(input longint v);
        if (v > 64'sd2147483647)
        begin
            sat_hit = 1'b1;
            return MAX32;
        end
        if (v < -64'sd2147483648)
        begin
            sat_hit = 1'b1;
            return MIN32;
        end
        return v[31:0];
    endfunction

    function automatic solution_t solve_system(input logic [8:0][31:0] v);
        longint a00, a10, a11, a20, a21, a22, nb0, nb1, nb2;
        longint l00, l10, l11, l20, l21, l22, d, y0, y1, y2, x0, x1, x2;
        solution_t s;
        a00 = signed'(v[0]); a10 = signed'(v[1]); a11 = signed'(v[2]);
        a20 = signed'(v[3]); a21 = signed'(v[4]); a22 = signed'(v[5]);
        nb0 = -longint'(signed'(v[6]));
        nb1 = -longint'(signed'(v[7]));
        nb2 = -longint'(signed'(v[8]));
        sat_hit = 1'b0;
        s = '{x0: '0, x1: '0, x2: '0, npd: 1'b1, ovf: 1'b0};
        if (a00 <= 0)
            return s;
        l00 = q_root(a00);
        l10 = q_div(a10, l00);
        d = q_sub(a11, q_mul(l10, l10));
        if (d <= 0)
            return s;
        l11 = q_root(d);
        l20 = q_div(a20, l00);
        l21 = q_div(q_sub(a21, q_mul(l20, l10)), l11);
        d = q_sub(q_sub(a22, q_mul(l20, l20)), q_mul(l21, l21));
        if (d <= 0)
            return s;
        l22 = q_root(d);
        y0 = q_div(nb0, l00);
        y1 = q_div(q_sub(nb1, q_mul(l10, y0)), l11);
        y2 = q_div(q_sub(q_sub(nb2, q_mul(l20, y0)), q_mul(l21, y1)), l22);
        x2 = q_div(y2, l22);
        x1 = q_div(q_sub(y1, q_mul(l21, x2)), l11);
        x0 = q_div(q_sub(q_sub(y0, q_mul(l10, x1)), q_mul(l20, x2)), l00);
        s.x0 = clamp_word(x0);
        s.x1 = clamp_word(x1);
        s.x2 = clamp_word(x2);
        s.npd = 1'b0;
        s.ovf = sat_hit;
        return s;
    endfunction

    function automatic logic [31:0] noise_word();
        logic [31:0] w;
        w = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -w : w;
    endfunction

    function automatic logic [8:0][31:0] random_system();
        logic [8:0][31:0] v;
        logic [31:0] dmin;
        int sh;
        for (int k = 0; k < 9; k++)
            v[k] = noise_word();
        if ($urandom_range(0, 9) < 7)
        begin
            sh = $urandom_range(0, 30);
            dmin = $urandom_range(1, 32'h7fff_ffff) >> sh;
            if (dmin == 0)
                dmin = 1;
            v[0] = dmin + ($urandom_range(0, MAX32 - dmin) >> sh);
            v[2] = dmin + ($urandom_range(0, MAX32 - dmin) >> sh);
            v[5] = dmin + ($urandom_range(0, MAX32 - dmin) >> sh);
            v[1] = $urandom_range(0, dmin / 3);
            v[3] = $urandom_range(0, dmin / 3);
            v[4] = $urandom_range(0, dmin / 3);
            if ($urandom_range(0, 1)) v[1] = -v[1];
            if ($urandom_range(0, 1)) v[3] = -v[3];
            if ($urandom_range(0, 1)) v[4] = -v[4];
        end
        return v;
    endfunction

    function automatic system_row_t make_row(input logic [8:0][31:0] v, input bit typed,
                                             input solution_t want);
        system_row_t r;
        r.v = v;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    task automatic send_system(input logic [8:0][31:0] v, input bit typed,
                               input solution_t want);
        @(negedge clk);
        drv = v;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_solutions.push_back(typed ? want : solve_system(v));
    endtask

    task automatic idle_input(input int n);
        @(negedge clk);
        in_valid = 1'b0;
        drv = {9{noise_word()}};
        repeat (n - 1) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        solution_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_solutions.size() == 0)
            begin
                $error("unexpected solution x_0=%h", x_0);
                fail_count++;
            end
            else
            begin
                e = pending_solutions.pop_front();
                if (x_0 !== e.x0)
                begin
                    $error("x_0 expected %h actual %h", e.x0, x_0);
                    fail_count++;
                end
                if (x_1 !== e.x1)
                begin
                    $error("x_1 expected %h actual %h", e.x1, x_1);
                    fail_count++;
                end
                if (x_2 !== e.x2)
                begin
                    $error("x_2 expected %h actual %h", e.x2, x_2);
                    fail_count++;
                end
                if (not_pos_definite !== e.npd)
                begin
                    $error("not_pos_definite expected %b actual %b", e.npd, not_pos_definite);
                    fail_count++;
                end
                if (overflowed !== e.ovf)
                begin
                    $error("overflowed expected %b actual %b", e.ovf, overflowed);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        int mode;
        if (cycle_count % 256 == 0)
            mode = $urandom_range(0, 3);
        case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((cycle_count / 7) % 2 == 1);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        solution_t npd_zero;
        solution_t any;
        logic [8:0][31:0] v;
        int burst;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        drv = '0;
        fail_count = 0;
        cycle_count = 0;
        npd_zero = '{x0: '0, x1: '0, x2: '0, npd: 1'b1, ovf: 1'b0};
        any = '0;

        table_rows.push_back(make_row('0, 1, npd_zero));
        table_rows.push_back(make_row({{8{32'd0}}, MIN32}, 1, npd_zero));
        table_rows.push_back(make_row({{3{32'd0}}, ONE_Q, 32'd0, 32'd0, ONE_Q,
                                       32'h0002_0000, ONE_Q}, 1, npd_zero));
        table_rows.push_back(make_row({{3{32'd0}}, 32'd0, 32'd0, 32'd0, ONE_Q,
                                       32'd0, ONE_Q}, 1, npd_zero));
        table_rows.push_back(make_row({{3{ONE_Q}}, ONE_Q, 32'd0, 32'd0, ONE_Q, 32'd0, ONE_Q},
                                      1, '{x0: -ONE_Q, x1: -ONE_Q, x2: -ONE_Q,
                                           npd: 1'b0, ovf: 1'b0}));
        table_rows.push_back(make_row({{3{32'd0}}, ONE_Q, 32'd0, 32'd0, ONE_Q, 32'd0, ONE_Q},
                                      1, '{x0: '0, x1: '0, x2: '0, npd: 1'b0, ovf: 1'b0}));
        table_rows.push_back(make_row({{3{MIN32}}, ONE_Q, 32'd0, 32'd0, ONE_Q, 32'd0, ONE_Q},
                                      1, '{x0: MAX32, x1: MAX32, x2: MAX32,
                                           npd: 1'b0, ovf: 1'b1}));
        table_rows.push_back(make_row({{3{MAX32}}, ONE_Q, 32'd0, 32'd0, ONE_Q, 32'd0, ONE_Q},
                                      1, '{x0: 32'h8000_0001, x1: 32'h8000_0001,
                                           x2: 32'h8000_0001, npd: 1'b0, ovf: 1'b0}));
        table_rows.push_back(make_row({{8{MAX32}}, 32'd1}, 0, any));
        table_rows.push_back(make_row({9{MAX32}}, 0, any));
        table_rows.push_back(make_row({{3{MIN32}}, MAX32, MIN32, MIN32, MAX32, MIN32, MAX32},
                                      0, any));
        table_rows.push_back(make_row({{3{MAX32}}, 32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1},
                                      0, any));
        table_rows.push_back(make_row({{3{32'hffff_ffff}}, 32'd1, 32'd0, 32'd0, 32'd1, 32'd0,
                                       32'd1}, 0, any));
        table_rows.push_back(make_row({32'h1234_5678, 32'hedcb_a987, 32'h0000_ffff,
                                       32'h0040_0000, 32'h0001_0000, 32'h0000_8000,
                                       32'h0100_0000, 32'hffff_0000, 32'h0040_0000},
                                      0, any));
        table_rows.push_back(make_row({32'h8000_0001, 32'h7fff_ffff, 32'h8000_0001,
                                       MAX32, 32'h7fff_ffff, MAX32,
                                       32'h7fff_ffff, 32'h7fff_ffff, MAX32}, 0, any));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (table_rows[i])
            send_system(table_rows[i].v, table_rows[i].typed, table_rows[i].want);
        idle_input(1);
        wait (pending_solutions.size() == 0);

        for (int n = 0; n < N_RANDOM; )
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
            begin
                v = random_system();
                send_system(v, 0, any);
            end
            if ($urandom_range(0, 3) != 0)
                idle_input($urandom_range(1, 12));
        end
        idle_input(1);

        wait (pending_solutions.size() == 0);
        repeat (LATENCY + 50) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// File: files.f
src/chs_pkg.sv
src/chs_op.sv
src/cholesky_solve_3x3_unit.sv
src/chs_checker.sv
bench/tb_top.sv
